// ===== hw/rtl/safety_mode_interlock_fsm_defines.svh =====
// Assertion macros for the mode interlock sequencer.
// Included by the top level; no other dependencies.
`ifndef SAFETY_MODE_INTERLOCK_FSM_DEFINES_SVH
`define SAFETY_MODE_INTERLOCK_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("interlock assertion failed");
// Next-cycle implication, disabled during reset.
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("interlock assertion failed");
`else
`define SMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/smi_pkg.sv =====
// Shared types, codes and helpers of the mode interlock sequencer.
// No dependencies; used by the interfaces and all modules.
package smi_pkg;

	localparam int MODE_W = 4;
	localparam int CODE_W = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Operating mode, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_DEV       = 9'b000000010,
		ST_DEV_CHECK = 9'b000000100,
		ST_STAND     = 9'b000001000,
		ST_WALK      = 9'b000010000,
		ST_DEV_SELF  = 9'b000100000,
		ST_GIMBAL    = 9'b001000000,
		ST_FOLLOW    = 9'b010000000,
		ST_ESTOP     = 9'b100000000
	} state_t;

	// Mode codes as seen on the result channel.
	localparam logic [MODE_W-1:0] MODE_IDLE      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_DEV       = 4'd1;
	localparam logic [MODE_W-1:0] MODE_DEV_CHECK = 4'd2;
	localparam logic [MODE_W-1:0] MODE_STAND     = 4'd3;
	localparam logic [MODE_W-1:0] MODE_WALK      = 4'd4;
	localparam logic [MODE_W-1:0] MODE_DEV_SELF  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_GIMBAL    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_FOLLOW    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ESTOP     = 4'd8;

	// Item kinds.
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_LEVEL   = 1'b1;

	// Request codes; anything above REQ_BACK_TO_GIMBAL is unknown.
	typedef enum logic [CODE_W-1:0] {
		REQ_ESTOP          = 4'd0,
		REQ_RESET          = 4'd1,
		REQ_IDLE           = 4'd2,
		REQ_CLEAR_ESTOP    = 4'd3,
		REQ_DEV_MODE       = 4'd4,
		REQ_DEV_CHECK_PASS = 4'd5,
		REQ_STAND_READY    = 4'd6,
		REQ_WALK_READY     = 4'd7,
		REQ_DEV_SELF_PASS  = 4'd8,
		REQ_GIMBAL_FOLLOW  = 4'd9,
		REQ_TARGET_FOLLOW  = 4'd10,
		REQ_BACK_TO_WALK   = 4'd11,
		REQ_BACK_TO_GIMBAL = 4'd12
	} req_code_t;

	// Register select (paddr bit 2).
	localparam logic REG_WALK_EN   = 1'b0;
	localparam logic REG_FOLLOW_EN = 1'b1;

	typedef struct packed {
		logic allow_walk;
		logic allow_follow;
	} cfg_t;

	typedef struct packed {
		state_t mode;
		logic   latch;
		logic   ext;
	} core_state_t;

	typedef struct packed {
		core_state_t nxt;
		logic        accepted;
		logic        motion_ok;
	} step_res_t;

	// Encode the one-hot mode as its output code.
	function automatic logic [MODE_W-1:0] mode_code(state_t s);
		logic [MODE_W-1:0] c;
		case (s)
			ST_IDLE:      c = MODE_IDLE;
			ST_DEV:       c = MODE_DEV;
			ST_DEV_CHECK: c = MODE_DEV_CHECK;
			ST_STAND:     c = MODE_STAND;
			ST_WALK:      c = MODE_WALK;
			ST_DEV_SELF:  c = MODE_DEV_SELF;
			ST_GIMBAL:    c = MODE_GIMBAL;
			ST_FOLLOW:    c = MODE_FOLLOW;
			ST_ESTOP:     c = MODE_ESTOP;
			default:      c = MODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/smi_ifs.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on smi_pkg for field widths.
interface smi_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [smi_pkg::CODE_W-1:0]  request_code;
	logic                        estop_level;

	modport source(output valid, mode, request_code, estop_level, input ready);
	modport sink(input valid, mode, request_code, estop_level, output ready);
endinterface

interface smi_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [smi_pkg::MODE_W-1:0]  current_mode;
	logic                        accepted;
	logic                        motion_ok;
	logic                        latched_out;

	modport source(output valid, current_mode, accepted, motion_ok, latched_out, input ready);
	modport sink(input valid, current_mode, accepted, motion_ok, latched_out, output ready);
endinterface

// ===== hw/rtl/smi_apb_regs.sv =====
// APB configuration registers: the walk and follow motion enables.
// Depends on smi_pkg. Address bit 2 selects the register, bits 1:0 are byte lanes.
module smi_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smi_pkg::ADDR_W-1:0]  paddr,
	input  logic [smi_pkg::DATA_W-1:0]  pwdata,
	output logic [smi_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output smi_pkg::cfg_t               cfg
);

	logic          wr_en;
	logic          reg_sel;
	smi_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[smi_pkg::ADDR_W-1];

	// Update the addressed enable at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allow_walk   <= 1'b0;
			cfg_q.allow_follow <= 1'b1;
		end else if (wr_en) begin
			if (reg_sel == smi_pkg::REG_WALK_EN) begin
				cfg_q.allow_walk <= pwdata[0];
			end else begin
				cfg_q.allow_follow <= pwdata[0];
			end
		end
	end

	// Return the addressed enable
	always_comb begin
		prdata = '0;
		if (reg_sel == smi_pkg::REG_WALK_EN) begin
			prdata[0] = cfg_q.allow_walk;
		end else begin
			prdata[0] = cfg_q.allow_follow;
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/smi_step.sv =====
// Next-mode logic: applies one request or e-stop level item to the mode state.
// Depends on smi_pkg; purely combinational.
module smi_step (
	input  smi_pkg::cfg_t                cfg,
	input  smi_pkg::core_state_t         cur,
	input  logic                         kind,
	input  logic [smi_pkg::CODE_W-1:0]   code,
	input  logic                         level,
	output smi_pkg::step_res_t           res
);

	smi_pkg::core_state_t nxt;
	logic                 ok;
	logic                 in_estop;
	logic                 nxt_estop;

	assign in_estop = (cur.mode == smi_pkg::ST_ESTOP) | cur.latch | cur.ext;

	// Decide the next mode, latch and external level
	always_comb begin
		nxt = cur;
		ok  = 1'b0;
		if (kind == smi_pkg::KIND_LEVEL) begin
			nxt.ext = level;
			if (level) begin
				nxt.mode  = smi_pkg::ST_ESTOP;
				nxt.latch = 1'b1;
			end
			ok = 1'b1;
		end else if (code == smi_pkg::REQ_ESTOP) begin
			nxt.mode  = smi_pkg::ST_ESTOP;
			nxt.latch = 1'b1;
			ok        = 1'b1;
		end else if (code inside {smi_pkg::REQ_RESET, smi_pkg::REQ_IDLE}) begin
			// refuse while the external stop is held, and latch it
			nxt.latch = 1'b1;
			nxt.mode  = smi_pkg::ST_ESTOP;
			if (!cur.ext) begin
				nxt.mode  = smi_pkg::ST_IDLE;
				nxt.latch = 1'b0;
				ok        = 1'b1;
			end
		end else if (in_estop) begin
			// apart from reset and idle, only a clear with the external stop released leaves e-stop
			if (code == smi_pkg::REQ_CLEAR_ESTOP && !cur.ext) begin
				nxt.mode  = smi_pkg::ST_IDLE;
				nxt.latch = 1'b0;
				ok        = 1'b1;
			end
		end else begin
			case (code)
				smi_pkg::REQ_DEV_MODE: begin
					if (cur.mode == smi_pkg::ST_IDLE) begin
						nxt.mode = smi_pkg::ST_DEV;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_DEV_CHECK_PASS: begin
					if (cur.mode == smi_pkg::ST_DEV) begin
						nxt.mode = smi_pkg::ST_DEV_CHECK;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_STAND_READY: begin
					if (cur.mode == smi_pkg::ST_DEV_CHECK) begin
						nxt.mode = smi_pkg::ST_STAND;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_WALK_READY: begin
					if (cur.mode == smi_pkg::ST_STAND) begin
						nxt.mode = smi_pkg::ST_WALK;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_DEV_SELF_PASS: begin
					if (cur.mode == smi_pkg::ST_WALK) begin
						nxt.mode = smi_pkg::ST_DEV_SELF;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_GIMBAL_FOLLOW: begin
					if (cur.mode == smi_pkg::ST_DEV_SELF) begin
						nxt.mode = smi_pkg::ST_GIMBAL;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_TARGET_FOLLOW: begin
					if (cur.mode == smi_pkg::ST_GIMBAL) begin
						nxt.mode = smi_pkg::ST_FOLLOW;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_BACK_TO_WALK: begin
					if (cur.mode == smi_pkg::ST_GIMBAL) begin
						nxt.mode = smi_pkg::ST_WALK;
						ok       = 1'b1;
					end
				end
				smi_pkg::REQ_BACK_TO_GIMBAL: begin
					if (cur.mode == smi_pkg::ST_FOLLOW) begin
						nxt.mode = smi_pkg::ST_GIMBAL;
						ok       = 1'b1;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	// Authorize motion from the new state
	assign nxt_estop = (nxt.mode == smi_pkg::ST_ESTOP) | nxt.latch | nxt.ext;

	always_comb begin
		res.nxt       = nxt;
		res.accepted  = ok;
		res.motion_ok = 1'b0;
		if (!nxt_estop) begin
			if (nxt.mode == smi_pkg::ST_WALK) begin
				res.motion_ok = cfg.allow_walk;
			end else if (nxt.mode == smi_pkg::ST_FOLLOW) begin
				res.motion_ok = cfg.allow_follow;
			end
		end
	end

endmodule

// ===== hw/rtl/safety_mode_interlock_fsm.sv =====
// Robot mode sequencer with e-stop interlock.
// Channels: req (sink) carries items: mode selects a mode request (0) or an
// external e-stop level update (1), with request_code and estop_level.
// rsp (source) carries one result per item: current_mode, accepted,
// motion_ok and latched_out, in item order.
// Configuration: APB write of the walk enable (0x0) and follow enable (0x4),
// bit 0 of pwdata; pready is always high; write only while no item is in flight.
// An accepted item is registered in the input register; its result is then
// registered in the result register and shown on rsp until it is taken.
// Throughput: one item per cycle while rsp is not stalled; the mode state feeds back
// into the next step through the result-stage logic.
// A stalled rsp holds its result; one more item waits in the input register,
// after which req.ready drops until rsp is taken.
// Reset (arst_n low): mode idle, latch and external level clear, walk enable 0,
// follow enable 1, both stages empty.
// Depends on smi_pkg, smi_ifs, smi_apb_regs, smi_step and the defines header.
`include "safety_mode_interlock_fsm_defines.svh"

module safety_mode_interlock_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	smi_req_if.sink                     req,
	smi_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smi_pkg::ADDR_W-1:0]  paddr,
	input  logic [smi_pkg::DATA_W-1:0]  pwdata,
	output logic [smi_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	smi_pkg::cfg_t               cfg;
	smi_pkg::core_state_t        st_q;
	smi_pkg::step_res_t          res;

	logic                        valid_s1;
	logic                        kind_s1;
	logic [smi_pkg::CODE_W-1:0]  code_s1;
	logic                        level_s1;

	logic                        valid_s2;
	logic [smi_pkg::MODE_W-1:0]  mode_s2;
	logic                        accepted_s2;
	logic                        motion_ok_s2;
	logic                        latched_s2;

	logic                        advance;
	logic                        take_in;

	smi_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smi_step u_step (
		.cfg   (cfg),
		.cur   (st_q),
		.kind  (kind_s1),
		.code  (code_s1),
		.level (level_s1),
		.res   (res)
	);

	// Move stage 1 forward when the result register is free or being taken
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take_in   = req.valid && req.ready;

	// Stage valids and mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			st_q.mode  <= smi_pkg::ST_IDLE;
			st_q.latch <= 1'b0;
			st_q.ext   <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				st_q <= res.nxt;
			end
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1  <= req.mode;
			code_s1  <= req.request_code;
			level_s1 <= req.estop_level;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			mode_s2      <= smi_pkg::mode_code(res.nxt.mode);
			accepted_s2  <= res.accepted;
			motion_ok_s2 <= res.motion_ok;
			latched_s2   <= res.nxt.latch;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.current_mode = mode_s2;
	assign rsp.accepted     = accepted_s2;
	assign rsp.motion_ok    = motion_ok_s2;
	assign rsp.latched_out  = latched_s2;

	// The latch only stands in e-stop mode
	`SMI_ASSERT_NOW(a_latch_in_estop, clk, arst_n, st_q.latch, st_q.mode == smi_pkg::ST_ESTOP)
	// A held external stop keeps the block in e-stop mode
	`SMI_ASSERT_NOW(a_ext_in_estop, clk, arst_n, st_q.ext, st_q.mode == smi_pkg::ST_ESTOP)
	// Motion is only reported in walk or follow mode with no latch
	`SMI_ASSERT_NOW(a_motion_mode, clk, arst_n, rsp.valid && rsp.motion_ok,
		!rsp.latched_out && (rsp.current_mode == smi_pkg::MODE_WALK ||
		rsp.current_mode == smi_pkg::MODE_FOLLOW))
	// Input back-pressure only when both stages are full and the output stalls
	`SMI_ASSERT_NOW(a_ready_drop, clk, arst_n, !req.ready, valid_s1 && valid_s2 && !rsp.ready)
	// A stage-1 item moving forward lands in the result register
	`SMI_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, valid_s1 && advance, valid_s2)

endmodule
